### rtl/iplpr_pkg.sv
// Shared types and constants for the IPv6 longest-prefix route core.
// No dependencies; every other rtl file refers to this package by scoped names.
package iplpr_pkg;

    localparam int AddrW   = 128;
    localparam int LenW    = 8;
    localparam int HopW    = 8;
    localparam int MaxLen  = 128;
    localparam int QDepth  = 2;
    localparam int QPtrW   = 1;
    localparam int QCntW   = 2;

    typedef logic [AddrW-1:0] t_addr;
    typedef logic [LenW-1:0]  t_len;
    typedef logic [HopW-1:0]  t_hop;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_DROP  = 2'd1,
        CMD_ROUTE = 2'd2
    } t_cmd_kind;

    typedef enum logic [1:0] {
        STAT_ROUTED   = 2'd0,
        STAT_DROPPED  = 2'd1,
        STAT_NO_ROUTE = 2'd2,
        STAT_WRITTEN  = 2'd3
    } t_status;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    // Classified work item passed from the front end to the lookup engine.
    // For a write, key is the prefix already masked to its length.
    typedef struct packed {
        t_cmd_kind   kind;
        logic [1:0]  entry_index;
        t_addr       key;
        t_addr       mask;
        t_len        len;
        t_hop        hop;
    } t_cmd;

    localparam t_addr AllOnes = {AddrW{1'b1}};

endpackage

### rtl/iplpr_front.sv
// Front end: classifies an incoming item into a table write, a hop-limit drop
// or a route lookup, and precomputes the prefix mask. Uses iplpr_pkg.
module iplpr_front (
    input  logic              i_op,
    input  logic [1:0]        i_entry_index,
    input  logic [63:0]       i_prefix_high,
    input  logic [63:0]       i_prefix_low,
    input  logic [7:0]        i_prefix_bits,
    input  logic [63:0]       i_dest_high,
    input  logic [63:0]       i_dest_low,
    input  logic [7:0]        i_hop_in,
    output iplpr_pkg::t_cmd   o_cmd
);

    iplpr_pkg::t_len  len_sat;
    iplpr_pkg::t_addr mask;

    always_comb begin
        // saturate overlong prefixes
        if (i_prefix_bits > iplpr_pkg::LenW'(iplpr_pkg::MaxLen)) begin
            len_sat = iplpr_pkg::LenW'(iplpr_pkg::MaxLen);
        end else begin
            len_sat = i_prefix_bits;
        end
        mask = ~(iplpr_pkg::AllOnes >> len_sat);

        o_cmd.entry_index = i_entry_index;
        o_cmd.mask        = '0;
        o_cmd.len         = '0;
        o_cmd.hop         = '0;
        if (!i_op) begin
            o_cmd.kind = iplpr_pkg::CMD_WRITE;
            o_cmd.key  = {i_prefix_high, i_prefix_low} & mask;
            o_cmd.mask = mask;
            o_cmd.len  = len_sat;
        end else if (i_hop_in == '0) begin
            o_cmd.kind = iplpr_pkg::CMD_DROP;
            o_cmd.key  = '0;
        end else begin
            o_cmd.kind = iplpr_pkg::CMD_ROUTE;
            o_cmd.key  = {i_dest_high, i_dest_low};
            o_cmd.hop  = i_hop_in - 8'd1;
        end
    end

endmodule

### rtl/iplpr_cmd_queue.sv
// Two-entry command queue between the front end and the lookup engine.
// Uses iplpr_pkg for the command type and queue sizing.
module iplpr_cmd_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  iplpr_pkg::t_cmd   i_cmd,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output iplpr_pkg::t_cmd   o_cmd
);

    iplpr_pkg::t_cmd                 r_mem [iplpr_pkg::QDepth];
    logic [iplpr_pkg::QPtrW-1:0]     r_wr_ptr;
    logic [iplpr_pkg::QPtrW-1:0]     r_rd_ptr;
    logic [iplpr_pkg::QCntW-1:0]     r_count;
    logic                            do_push;
    logic                            do_pop;

    assign o_full  = (r_count == iplpr_pkg::QCntW'(iplpr_pkg::QDepth));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

### rtl/iplpr_back.sv
// Lookup engine: owns the route table, carries out writes and scans one entry
// per cycle for the longest match. Holds the result register. Uses iplpr_pkg.
module iplpr_back #(
    parameter int ENTRIES = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  iplpr_pkg::t_cmd   i_cmd,
    output logic              o_q_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [1:0]        o_status,
    output logic [1:0]        o_out_interface,
    output logic [7:0]        o_hop_out
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    // route table
    iplpr_pkg::t_addr r_tbl_key  [ENTRIES];
    iplpr_pkg::t_addr r_tbl_mask [ENTRIES];
    iplpr_pkg::t_len  r_tbl_len  [ENTRIES];
    logic [ENTRIES-1:0] r_valid;

    iplpr_pkg::t_state r_state, n_state;
    logic [CW-1:0]     r_addr, n_addr;

    logic              r_rd_vld;
    logic [IW-1:0]     r_rd_idx;
    iplpr_pkg::t_addr  r_rd_key;
    iplpr_pkg::t_addr  r_rd_mask;
    iplpr_pkg::t_len   r_rd_len;

    iplpr_pkg::t_addr  r_dest;
    iplpr_pkg::t_hop   r_hop;
    logic              r_best_vld;
    logic [IW-1:0]     r_best_idx;
    iplpr_pkg::t_len   r_best_len;

    logic              r_res_vld;
    iplpr_pkg::t_status r_res_status;
    logic [1:0]        r_res_if;
    iplpr_pkg::t_hop   r_res_hop;

    logic              slot_free;
    logic              wr_en;
    logic              rd_en;
    logic              start;
    logic              hit;
    logic              better;
    logic              res_load;
    iplpr_pkg::t_status res_status;
    logic [1:0]        res_if;
    iplpr_pkg::t_hop   res_hop;
    logic              wr_ok;
    logic [IW-1:0]     wr_addr;

    assign slot_free = !r_res_vld || i_pop;
    assign wr_ok     = (32'(i_cmd.entry_index) < ENTRIES);
    assign wr_addr   = IW'(i_cmd.entry_index);
    assign hit       = ((r_dest & r_rd_mask) == r_rd_key);
    assign better    = r_rd_vld && r_valid[r_rd_idx] && hit
                       && (!r_best_vld || (r_rd_len > r_best_len));

    assign o_empty         = !r_res_vld;
    assign o_status        = r_res_status;
    assign o_out_interface = r_res_if;
    assign o_hop_out       = r_res_hop;

    always_comb begin
        n_state    = r_state;
        n_addr     = r_addr;
        o_q_pop    = 1'b0;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        start      = 1'b0;
        res_load   = 1'b0;
        res_status = iplpr_pkg::STAT_WRITTEN;
        res_if     = '0;
        res_hop    = '0;
        case (r_state)
            iplpr_pkg::ST_IDLE: begin
                if (!i_q_empty) begin
                    case (i_cmd.kind)
                        iplpr_pkg::CMD_ROUTE: begin
                            o_q_pop = 1'b1;
                            start   = 1'b1;
                            n_addr  = '0;
                            n_state = iplpr_pkg::ST_SCAN;
                        end
                        iplpr_pkg::CMD_WRITE: begin
                            if (slot_free) begin
                                o_q_pop  = 1'b1;
                                wr_en    = wr_ok;
                                res_load = 1'b1;
                            end
                        end
                        default: begin
                            if (slot_free) begin
                                o_q_pop    = 1'b1;
                                res_load   = 1'b1;
                                res_status = iplpr_pkg::STAT_DROPPED;
                            end
                        end
                    endcase
                end
            end
            iplpr_pkg::ST_SCAN: begin
                if (r_addr != CW'(ENTRIES)) begin
                    rd_en  = 1'b1;
                    n_addr = r_addr + 1'b1;
                end else if (!r_rd_vld && slot_free) begin
                    // last compare has landed in the best-match registers
                    res_load = 1'b1;
                    res_hop  = r_hop;
                    if (r_best_vld) begin
                        res_status = iplpr_pkg::STAT_ROUTED;
                        res_if     = 2'(r_best_idx);
                    end else begin
                        res_status = iplpr_pkg::STAT_NO_ROUTE;
                    end
                    n_state = iplpr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = iplpr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= iplpr_pkg::ST_IDLE;
            r_addr     <= '0;
            r_valid    <= '0;
            r_rd_vld   <= 1'b0;
            r_best_vld <= 1'b0;
            r_res_vld  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_addr   <= n_addr;
            r_rd_vld <= rd_en;
            if (wr_en) begin
                r_valid[wr_addr] <= 1'b1;
            end
            if (start) begin
                r_best_vld <= 1'b0;
            end else if (better) begin
                r_best_vld <= 1'b1;
            end
            if (res_load) begin
                r_res_vld <= 1'b1;
            end else if (i_pop) begin
                r_res_vld <= 1'b0;
            end
        end
    end

    // table write port and registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_tbl_key[wr_addr]  <= i_cmd.key;
            r_tbl_mask[wr_addr] <= i_cmd.mask;
            r_tbl_len[wr_addr]  <= i_cmd.len;
        end
        if (rd_en) begin
            r_rd_key  <= r_tbl_key[r_addr[IW-1:0]];
            r_rd_mask <= r_tbl_mask[r_addr[IW-1:0]];
            r_rd_len  <= r_tbl_len[r_addr[IW-1:0]];
        end
        r_rd_idx <= r_addr[IW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_dest <= i_cmd.key;
            r_hop  <= i_cmd.hop;
        end
        if (better) begin
            r_best_idx <= r_rd_idx;
            r_best_len <= r_rd_len;
        end
        if (res_load) begin
            r_res_status <= res_status;
            r_res_if     <= res_if;
            r_res_hop    <= res_hop;
        end
    end

endmodule

### rtl/ipv6_longest_prefix_route_core.sv
// IPv6 longest-prefix route core, top level.
// Depends on iplpr_pkg, iplpr_front, iplpr_cmd_queue and iplpr_back.
//
// Usage:
//   Input side is a queue: drive the item fields and raise push; the item
//   transfers on a rising edge with push high and full low. op = 0 loads a
//   table entry, op = 1 routes a packet or drops it when i_hop_in is zero.
//   Result side is a queue: while empty is low the oldest result is on
//   o_status, o_out_interface and o_hop_out; it transfers on a rising edge
//   with pop high. Exactly one result per item, in order.
//   A two-entry command queue sits between the classifier and the lookup
//   engine, so items keep arriving while a result waits to be taken.
//   Order: a write or a hop-limit drop goes from the command queue straight
//   into the result register. A route holds the engine while the scan reads
//   one table entry per cycle from the single read port into the read and
//   best-match registers, and then loads the result register.
//   Reset (synchronous, i_rst_n low) empties both queues and clears every
//   valid mark; table contents are kept but unused until rewritten.
//   If the receiver stalls, the engine holds its finished result and the
//   command queue fills; full then rises and holds off the sender.
module ipv6_longest_prefix_route_core #(
    parameter int ENTRIES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_op,
    input  logic [1:0]  i_entry_index,
    input  logic [63:0] i_prefix_high,
    input  logic [63:0] i_prefix_low,
    input  logic [7:0]  i_prefix_bits,
    input  logic [63:0] i_dest_high,
    input  logic [63:0] i_dest_low,
    input  logic [7:0]  i_hop_in,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_status,
    output logic [1:0]  o_out_interface,
    output logic [7:0]  o_hop_out
);

    iplpr_pkg::t_cmd front_cmd;
    iplpr_pkg::t_cmd q_cmd;
    logic            q_empty;
    logic            q_pop;

    iplpr_front u_front (
        .i_op          (i_op),
        .i_entry_index (i_entry_index),
        .i_prefix_high (i_prefix_high),
        .i_prefix_low  (i_prefix_low),
        .i_prefix_bits (i_prefix_bits),
        .i_dest_high   (i_dest_high),
        .i_dest_low    (i_dest_low),
        .i_hop_in      (i_hop_in),
        .o_cmd         (front_cmd)
    );

    iplpr_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (q_cmd)
    );

    iplpr_back #(
        .ENTRIES (ENTRIES)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_empty       (q_empty),
        .i_cmd           (q_cmd),
        .o_q_pop         (q_pop),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_status        (o_status),
        .o_out_interface (o_out_interface),
        .o_hop_out       (o_hop_out)
    );

endmodule
